// ===== hw/rtl/mlz_pkg.sv =====
// shared types and constants for the marker lz decompressor
`timescale 1ns / 1ps
`default_nettype none
package mlz_pkg;

  localparam int HISTORY_DEPTH = 2048;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int LEN_BITS      = 5;
  localparam int MIN_LEN       = 3;
  localparam int LEN_W         = $clog2((1 << LEN_BITS) + MIN_LEN);
  localparam int OFF_W         = 11;
  localparam int WORD_W        = 16;

  typedef enum logic [1:0] {
    PH_TOKEN = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_LITERAL = 2'd1,
    OP_BAD     = 2'd2,
    OP_COPY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } eng_state_t;

  typedef struct packed {
    logic             go;
    logic             clear_ptr;
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic [OFF_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } eng_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mlz_stream_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface mlz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink (input valid, input in_byte, input new_stream, output ready);
endinterface

interface mlz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       bad_offset;

  modport source (output valid, output out_byte, output run_last, output bad_offset,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input bad_offset,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlz_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module mlz_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mlz_engine.sv =====
// copy sequencer: history pointer, history ram and result register
`timescale 1ns / 1ps
`default_nettype none
module mlz_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mlz_pkg::cmd_t      cmd,
  output mlz_pkg::eng_stat_t      stat,
  mlz_out_if.source               res
);

  mlz_pkg::eng_state_t state, state_next;
  logic [mlz_pkg::PTR_W-1:0] wp, wp_next;
  logic [mlz_pkg::PTR_W-1:0] src, src_next;
  logic [mlz_pkg::LEN_W-1:0] count, count_next;
  logic [mlz_pkg::PTR_W-1:0] wp_base;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_bad;
  logic       out_free;
  logic       out_load;
  logic [7:0] load_byte;
  logic       load_last;
  logic       load_bad;

  logic                      ram_we;
  logic [mlz_pkg::PTR_W-1:0] ram_waddr;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [7:0]                ram_rdata;

  mlz_ram #(
    .DEPTH(mlz_pkg::HISTORY_DEPTH),
    .WIDTH(8)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(src),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlz_pkg::ST_IDLE;
      wp    <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    src   <= src_next;
    count <= count_next;
  end

  always_comb begin
    out_free   = !out_valid || res.ready;
    state_next = state;
    wp_next    = wp;
    src_next   = src;
    count_next = count;
    wp_base    = cmd.clear_ptr ? '0 : wp;
    out_load   = 1'b0;
    load_byte  = cmd.data;
    load_last  = 1'b1;
    load_bad   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wp;
    ram_wdata  = cmd.data;
    ram_re     = 1'b0;
    stat.ready = 1'b0;
    stat.busy  = 1'b1;

    unique case (state)
      mlz_pkg::ST_IDLE: begin
        stat.ready = out_free;
        stat.busy  = 1'b0;
        if (cmd.go) begin
          wp_next = wp_base;
          unique case (cmd.op)
            mlz_pkg::OP_LITERAL: begin
              out_load  = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = wp_base;
              wp_next   = wp_base + mlz_pkg::PTR_W'(1);
            end
            mlz_pkg::OP_BAD: begin
              out_load  = 1'b1;
              load_byte = 8'd0;
              load_bad  = 1'b1;
            end
            mlz_pkg::OP_COPY: begin
              // offset wraps modulo the history depth
              src_next   = wp_base - mlz_pkg::PTR_W'(cmd.offset);
              count_next = cmd.length;
              state_next = mlz_pkg::ST_READ;
            end
            mlz_pkg::OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      mlz_pkg::ST_READ: begin
        ram_re     = 1'b1;
        state_next = mlz_pkg::ST_EMIT;
      end
      mlz_pkg::ST_EMIT: begin
        // read data holds in the ram output until the result slot frees
        if (out_free) begin
          out_load   = 1'b1;
          load_byte  = ram_rdata;
          load_last  = (count == mlz_pkg::LEN_W'(1));
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata;
          wp_next    = wp + mlz_pkg::PTR_W'(1);
          src_next   = src + mlz_pkg::PTR_W'(1);
          count_next = count - mlz_pkg::LEN_W'(1);
          state_next = (count == mlz_pkg::LEN_W'(1)) ? mlz_pkg::ST_IDLE : mlz_pkg::ST_READ;
        end
      end
      default: begin
        state_next = mlz_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= load_byte;
      out_last <= load_last;
      out_bad  <= load_bad;
    end
  end

  assign res.valid      = out_valid;
  assign res.out_byte   = out_byte;
  assign res.run_last   = out_last;
  assign res.bad_offset = out_bad;

endmodule
`default_nettype wire

// ===== hw/rtl/marker_lz_decompressor_top.sv =====
// Marker-escaped LZ77 byte decoder.
// in_req carries one compressed byte per request (in_byte, new_stream); a request
// is taken when valid and ready are both high. out_res carries decoded bytes with
// run_last on the final byte a request causes and bad_offset for a zero offset.
// cfg_we/cfg_wdata write the marker byte; write it only while the block is idle.
// A literal, an escaped marker or a zero-offset error shows on out_res the cycle
// after the request is taken. A marker or low command byte gives no result. For
// each byte of a copy, the history ram (one write port, one read port) is read
// into its output register, then the byte is written back and loaded into the
// result register once that register is free. in_req is not ready during a copy.
// A result waits in the output register while out_res.ready is low; the
// sequencer and in_req.ready hold until the register frees.
// Reset (rst, synchronous) clears the parse phase, the history pointer, the
// marker byte and the output valid; the history ram keeps its contents and
// needs no clearing pass. new_stream restarts parsing and the pointer.
`timescale 1ns / 1ps
`default_nettype none
module marker_lz_decompressor_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  mlz_in_if.sink          in_req,
  mlz_out_if.source       out_res
);

  logic [7:0]             marker_byte;
  mlz_pkg::phase_t        phase, phase_next, phase_cur;
  logic [7:0]             low_byte, low_byte_next;
  logic [mlz_pkg::WORD_W-1:0] word;
  logic                   accept;
  mlz_pkg::cmd_t          cmd;
  mlz_pkg::eng_stat_t     stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_byte <= 8'd0;
    end else if (cfg_we) begin
      marker_byte <= cfg_wdata;
    end
  end

  assign in_req.ready = stat.ready;
  assign accept       = in_req.valid && stat.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= mlz_pkg::PH_TOKEN;
      low_byte <= 8'd0;
    end else begin
      phase    <= phase_next;
      low_byte <= low_byte_next;
    end
  end

  always_comb begin
    phase_cur     = in_req.new_stream ? mlz_pkg::PH_TOKEN : phase;
    word          = {in_req.in_byte, low_byte};
    phase_next    = phase;
    low_byte_next = low_byte;
    cmd.go        = accept;
    cmd.clear_ptr = in_req.new_stream;
    cmd.op        = mlz_pkg::OP_NONE;
    cmd.data      = in_req.in_byte;
    cmd.length    = mlz_pkg::LEN_W'(word[mlz_pkg::LEN_BITS-1:0])
                    + mlz_pkg::LEN_W'(mlz_pkg::MIN_LEN);
    cmd.offset    = mlz_pkg::OFF_W'(word >> mlz_pkg::LEN_BITS);

    unique case (phase_cur)
      mlz_pkg::PH_LOW: begin
        phase_next    = mlz_pkg::PH_HIGH;
        low_byte_next = in_req.in_byte;
      end
      mlz_pkg::PH_HIGH: begin
        phase_next = mlz_pkg::PH_TOKEN;
        if (word == '0) begin
          // escaped marker
          cmd.op   = mlz_pkg::OP_LITERAL;
          cmd.data = marker_byte;
        end else if (cmd.offset == '0) begin
          cmd.op = mlz_pkg::OP_BAD;
        end else begin
          cmd.op = mlz_pkg::OP_COPY;
        end
      end
      default: begin
        // expecting a token; the unused phase code lands here too
        if (in_req.in_byte == marker_byte) begin
          phase_next = mlz_pkg::PH_LOW;
        end else begin
          phase_next = mlz_pkg::PH_TOKEN;
          cmd.op     = mlz_pkg::OP_LITERAL;
        end
      end
    endcase

    if (!accept) begin
      phase_next    = phase;
      low_byte_next = low_byte;
    end else if (in_req.new_stream && phase_cur == mlz_pkg::PH_TOKEN &&
                 phase_next != mlz_pkg::PH_LOW) begin
      low_byte_next = 8'd0;
    end
  end

  mlz_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .stat(stat),
    .res (out_res)
  );

`ifndef SYNTHESIS
  a_ready_needs_slot: assert property (@(posedge clk) disable iff (rst)
    in_req.ready |-> (!out_res.valid || out_res.ready))
    else $error("request taken while result slot is blocked");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_req.ready)
    else $error("request ready during copy");

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    (out_res.valid && out_res.bad_offset) |-> (out_res.run_last && out_res.out_byte == 8'd0))
    else $error("bad offset result malformed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_res.valid && !stat.busy))
    else $error("reset did not clear result or sequencer");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_marker_lz_decompressor_top.sv =====
// self-checking testbench for the marker lz decompressor top level
`timescale 1ns / 1ps
module tb_marker_lz_decompressor_top;

  localparam int         STALL_LIMIT     = 2000;
  localparam int         PHASE_ITEMS     = 22;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         DRAIN_CYCLES    = 20;
  localparam logic [7:0] DIRECTED_MARKER = 8'hA5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       bad_offset;
  } dec_byte_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
    logic       typed;
    dec_byte_t  want;
  } directed_row_t;

  localparam dec_byte_t NO_RESULT = '0;

  // marker is DIRECTED_MARKER throughout; rows with typed clear go to the predictor
  directed_row_t directed_rows [0:21] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},          // literal zero, fresh stream
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{8'h5A, 1'b0, 1'b1, '{8'h5A, 1'b1, 1'b0}},
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, '{DIRECTED_MARKER, 1'b1, 1'b0}}, // escaped marker
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'h9F, 1'b0, 1'b0, NO_RESULT},                      // longest copy, offset 4
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'h20, 1'b0, 1'b0, NO_RESULT},                      // shortest copy, offset 1
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'h1F, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1}},          // zero offset
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'hE0, 1'b0, 1'b0, NO_RESULT},
    '{8'h3C, 1'b1, 1'b1, '{8'h3C, 1'b1, 1'b0}},          // new stream drops the command
    '{8'h7E, 1'b0, 1'b1, '{8'h7E, 1'b1, 1'b0}},
    '{DIRECTED_MARKER, 1'b0, 1'b0, NO_RESULT},
    '{8'h40, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}                       // overlapping copy, offset 2
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  mlz_in_if  in_req ();
  mlz_out_if out_res ();

  marker_lz_decompressor_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_res   (out_res)
  );

  always #10 clk = ~clk;

  // decoder state mirrored by the testbench
  logic [7:0]                marker;
  mlz_pkg::phase_t           cur_phase;
  logic [7:0]                cmd_low;
  logic [mlz_pkg::PTR_W-1:0] wr_ptr;
  logic [7:0]                hist [mlz_pkg::HISTORY_DEPTH];
  bit                        hist_ok [mlz_pkg::HISTORY_DEPTH];

  dec_byte_t        pending_bytes [$];
  dec_byte_t        step_bytes [$];

  // low command byte already chosen together with its high byte
  logic             plan_set;
  logic [7:0]       plan_hi;

  bit               steady;
  int               mismatches;
  int               stall_cycles;

  task automatic store_byte(input logic [7:0] v);
    hist[wr_ptr]    = v;
    hist_ok[wr_ptr] = 1'b1;
    wr_ptr = wr_ptr + 1'b1;
  endtask

  task automatic decode_request(input logic [7:0] b, input logic ns);
    logic [15:0]               word;
    logic [mlz_pkg::OFF_W-1:0] off;
    logic [mlz_pkg::PTR_W-1:0] src;
    logic [7:0]                v;
    int unsigned               span;
    step_bytes.delete();
    if (ns) begin
      cur_phase = mlz_pkg::PH_TOKEN;
      cmd_low   = 8'h00;
      wr_ptr    = '0;
    end
    case (cur_phase)
      mlz_pkg::PH_LOW: begin
        cmd_low   = b;
        cur_phase = mlz_pkg::PH_HIGH;
      end
      mlz_pkg::PH_HIGH: begin
        cur_phase = mlz_pkg::PH_TOKEN;
        word = {b, cmd_low};
        if (word == 16'h0000) begin
          store_byte(marker);
          step_bytes.push_back(dec_byte_t'{marker, 1'b1, 1'b0});
        end else begin
          span = word[mlz_pkg::LEN_BITS-1:0] + mlz_pkg::MIN_LEN;
          off  = word[15:mlz_pkg::LEN_BITS];
          if (off == '0) begin
            step_bytes.push_back(dec_byte_t'{8'h00, 1'b1, 1'b1});
          end else begin
            src = wr_ptr - off;
            for (int unsigned i = 0; i < span; i++) begin
              v = hist[src];
              store_byte(v);
              src = src + 1'b1;
              step_bytes.push_back(dec_byte_t'{v, (i + 1 == span), 1'b0});
            end
          end
        end
      end
      default: begin
        cur_phase = mlz_pkg::PH_TOKEN;
        if (b == marker) begin
          cur_phase = mlz_pkg::PH_LOW;
        end else begin
          store_byte(b);
          step_bytes.push_back(dec_byte_t'{b, 1'b1, 1'b0});
        end
      end
    endcase
  endtask

  // how far back from a pointer the history holds written bytes without a gap
  function automatic int history_reach(input logic [mlz_pkg::PTR_W-1:0] from);
    int                        k;
    logic [mlz_pkg::PTR_W-1:0] p;
    k = 0;
    p = from - 1'b1;
    while (k < mlz_pkg::HISTORY_DEPTH - 1 && hist_ok[p]) begin
      k++;
      p = p - 1'b1;
    end
    return k;
  endfunction

  // copies only reach back over history bytes that were written
  task automatic next_request(output logic [7:0] b, output logic ns);
    mlz_pkg::phase_t ph;
    int              reach;
    int              r;
    int              off;
    logic [4:0]      len;
    ns    = ($urandom_range(99) < 6);
    ph    = ns ? mlz_pkg::PH_TOKEN : cur_phase;
    reach = history_reach(ns ? '0 : wr_ptr);
    case (ph)
      mlz_pkg::PH_LOW: begin
        r        = $urandom_range(99);
        len      = 5'($urandom_range(31));
        plan_set = 1'b1;
        if (r < 12) begin
          b       = 8'h00;
          plan_hi = 8'h00;
        end else if (r < 22) begin
          b       = 8'($urandom_range(1, 31));
          plan_hi = 8'h00;
        end else if (r < 34 && reach == mlz_pkg::HISTORY_DEPTH - 1) begin
          // whole history holds known bytes, so any offset is safe
          b        = 8'($urandom);
          plan_set = 1'b0;
        end else begin
          if (reach == 0) off = 0;
          else if (r < 70) off = $urandom_range(1, (reach < 40) ? reach : 40);
          else if (r < 75) off = reach;
          else off = $urandom_range(1, reach);
          b       = {off[2:0], len};
          plan_hi = off[10:3];
        end
      end
      mlz_pkg::PH_HIGH: b = plan_set ? plan_hi : 8'($urandom);
      default: b = ($urandom_range(99) < 45) ? marker : 8'($urandom);
    endcase
  endtask

  task automatic push_request(input logic [7:0] b, input logic ns, input logic typed,
                              input dec_byte_t want);
    while (!steady && $urandom_range(99) < 34) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.in_byte    <= b;
    in_req.new_stream <= ns;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    decode_request(b, ns);
    if (typed) pending_bytes.push_back(want);
    else foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
  endtask

  // marker changes only with the block idle; a trailing marker byte gives no result
  task automatic write_marker(input logic [7:0] m);
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker = m;
  endtask

  always @(posedge clk) begin
    out_res.ready <= !rst && (steady || $urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    dec_byte_t got;
    dec_byte_t want;
    if (!rst && out_res.valid && out_res.ready) begin
      got = '{out_res.out_byte, out_res.run_last, out_res.bad_offset};
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: out_byte=%02h run_last=%0b bad_offset=%0b",
                   got.out_byte, got.run_last, got.bad_offset);
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.bad_offset !== want.bad_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.out_byte, want.run_last, want.bad_offset,
                     got.out_byte, got.run_last, got.bad_offset);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("marker_lz_decompressor_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    logic       ns;
    logic [7:0] phase_marker [4];
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = 8'h00;
    in_req.valid      = 1'b0;
    in_req.in_byte    = 8'h00;
    in_req.new_stream = 1'b0;
    out_res.ready     = 1'b0;
    steady            = 1'b0;
    mismatches        = 0;
    stall_cycles      = 0;
    marker            = 8'h00;
    cur_phase         = mlz_pkg::PH_TOKEN;
    cmd_low           = 8'h00;
    wr_ptr            = '0;
    plan_set          = 1'b0;
    plan_hi           = 8'h00;
    foreach (hist_ok[i]) hist_ok[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_marker(DIRECTED_MARKER);
    foreach (directed_rows[i])
      push_request(directed_rows[i].in_byte, directed_rows[i].new_stream,
                   directed_rows[i].typed, directed_rows[i].want);

    // the first random phase runs with no idling on either side
    phase_marker = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    foreach (phase_marker[p]) begin
      write_marker(phase_marker[p]);
      steady = (p == 0);
      repeat (PHASE_ITEMS) begin
        next_request(b, ns);
        push_request(b, ns, 1'b0, NO_RESULT);
      end
    end
    steady = 1'b0;

    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0)
      $display("marker_lz_decompressor_top verification clean");
    else
      $display("marker_lz_decompressor_top verification failed");
    $finish;
  end

endmodule

// ===== marker_lz_decompressor_top.f =====
hw/rtl/mlz_pkg.sv
hw/rtl/mlz_stream_if.sv
hw/rtl/mlz_ram.sv
hw/rtl/mlz_engine.sv
hw/rtl/marker_lz_decompressor_top.sv
dv/tb_marker_lz_decompressor_top.sv
